/* rtl/core/b64enc_pkg.sv */
// Shared types, constants and the sextet-to-character function of the Base64 encoder.
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam int BYTE_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int SEXTET_W  = 6;
    localparam int MAX_CHARS = 4;
    localparam int IDX_W     = $clog2(MAX_CHARS);

    localparam logic [SEXTET_W-1:0] SEXTET_MASK = 6'h3F;
    localparam logic [CHAR_W-1:0]   PAD_CHAR    = 7'h3D;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CH_LOWER_OFS = 7'd71;
    localparam logic [CHAR_W-1:0] CH_DIGIT_SUB = 7'd4;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 7'd43;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 7'd47;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'd45;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 7'd95;

    // Position within the three-byte group.
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // Characters caused by one input byte, handed from encoder to emitter.
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             last;
    } t_group;

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v,
                                                      input logic url_safe);
        logic [SEXTET_W-1:0] s;
        logic [CHAR_W-1:0]   c;
        s = v & SEXTET_MASK;
        if (s < 6'd26) begin
            c = CH_UPPER_A + CHAR_W'(s);
        end else if (s < 6'd52) begin
            c = CHAR_W'(s) + CH_LOWER_OFS;
        end else if (s < 6'd62) begin
            c = CHAR_W'(s) - CH_DIGIT_SUB;
        end else if (s == 6'd62) begin
            c = url_safe ? CH_MINUS : CH_PLUS;
        end else begin
            c = url_safe ? CH_UNDER : CH_SLASH;
        end
        return c;
    endfunction

endpackage

/* rtl/core/b64enc_encode.sv */
// Group-phase state, mode register and per-byte character generation.
`timescale 1ns / 1ps

module b64enc_encode
    import b64enc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_write,
    input  logic              i_cfg_url_safe_mode,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_accept,
    output t_group            o_group
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_left, n_left;
    logic        r_url_safe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_0;
            r_left     <= 4'd0;
            r_url_safe <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_url_safe <= i_cfg_url_safe_mode;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_left  <= n_left;
            end
        end
    end

    always_comb begin
        o_group.chars[2] = PAD_CHAR;
        o_group.chars[3] = PAD_CHAR;
        o_group.last     = i_last_byte;
        unique case (r_phase)
            PH_1: begin
                o_group.chars[0] = sextet_char({r_left[1:0], i_data_byte[7:4]}, r_url_safe);
                o_group.chars[1] = sextet_char({i_data_byte[3:0], 2'b00}, r_url_safe);
                o_group.last_idx = !i_last_byte ? IDX_W'(0) : (r_url_safe ? IDX_W'(1)
                                                                          : IDX_W'(2));
                n_phase          = PH_2;
                n_left           = i_data_byte[3:0];
            end
            PH_2: begin
                o_group.chars[0] = sextet_char({r_left, i_data_byte[7:6]}, r_url_safe);
                o_group.chars[1] = sextet_char(i_data_byte[5:0], r_url_safe);
                o_group.last_idx = IDX_W'(1);
                n_phase          = PH_0;
                n_left           = 4'd0;
            end
            default: begin
                // Start of a group; an unused phase code behaves the same way.
                o_group.chars[0] = sextet_char(i_data_byte[7:2], r_url_safe);
                o_group.chars[1] = sextet_char({i_data_byte[1:0], 4'b0000}, r_url_safe);
                o_group.last_idx = !i_last_byte ? IDX_W'(0) : (r_url_safe ? IDX_W'(1)
                                                                          : IDX_W'(3));
                n_phase          = PH_1;
                n_left           = {2'b00, i_data_byte[1:0]};
            end
        endcase
        if (i_last_byte) begin
            n_phase = PH_0;
            n_left  = 4'd0;
        end
    end

endmodule

/* rtl/core/b64enc_emit.sv */
// Result register holding one byte's characters and presenting them one per transfer.
`timescale 1ns / 1ps

module b64enc_emit
    import b64enc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_group            i_group,
    input  logic              i_load,
    input  logic              i_out_ready,
    output logic              o_free,
    output logic              o_out_valid,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_last_char
);

    t_group           r_grp;
    logic             r_valid;
    logic [IDX_W-1:0] r_idx;
    logic             at_end;
    logic             pop;

    assign at_end      = (r_idx == r_grp.last_idx);
    assign pop         = r_valid && i_out_ready;
    assign o_free      = !r_valid || (i_out_ready && at_end);
    assign o_out_valid = r_valid;
    assign o_out_char  = r_grp.chars[r_idx];
    assign o_last_char = r_grp.last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (pop && at_end) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

`ifndef SYNTH
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_grp.last_idx))
        else $error("character index beyond the end of its group");

    a_idx_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !at_end && !i_load) |=> (r_valid && r_idx == $past(r_idx) + IDX_W'(1)))
        else $error("character index did not advance after a transfer");

    a_last_ends_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && o_last_char) |=> (!r_valid || r_idx == '0))
        else $error("characters left over after the final character");
`endif

endmodule

/* rtl/core/base64_stream_encoder_top.sv */
// Top level of the Base64 stream encoder: byte input, character output, mode register.
`timescale 1ns / 1ps
//
// Usage
// -----
// Input channel (i_in_valid / o_in_ready): one raw byte per transfer, with
// i_last_byte high on the final byte of a message. Output channel
// (o_out_valid / i_out_ready): one ASCII Base64 character per transfer, with
// o_last_char high on the final character of the message. The configuration
// channel (i_cfg_valid / o_cfg_ready) writes the url_safe_mode bit: 0 gives
// the standard alphabet with '=' padding, 1 the URL-safe alphabet without
// padding. It is always ready and should only be written while idle.
// Each byte yields one to four characters, which are computed in the cycle
// the byte transfers and are held in a result register; the first appears on
// the output in the cycle after the input transfer. The output delivers one
// character per cycle while the receiver is ready, and a new byte is taken
// in the same cycle as the last character of the previous byte leaves, so
// no gap opens (about 1.33 characters per byte in a long message).
// If the receiver stalls, the current character is held and o_in_ready falls
// once the result register cannot be emptied. Reset returns the group phase,
// the leftover bits and the mode bit to zero and discards pending characters.
//

module base64_stream_encoder_top
    import b64enc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_url_safe_mode,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_last_char
);

    t_group group;
    logic   free;
    logic   accept;

    // The configuration register can take a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = free;
    assign accept      = i_in_valid && free;

    b64enc_encode u_encode (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_write         (i_cfg_valid),
        .i_cfg_url_safe_mode (i_cfg_url_safe_mode),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .i_accept            (accept),
        .o_group             (group)
    );

    b64enc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_group     (group),
        .i_load      (accept),
        .i_out_ready (i_out_ready),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

/* tb/b64enc_checker.sv */
// Checker for the Base64 stream encoder: predicts every character and compares each output transfer.
`timescale 1ns / 1ps

module b64enc_checker
    import b64enc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_url_safe_mode,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [CHAR_W-1:0] i_out_char,
    input  logic              i_last_char,
    output int                o_fail_count,
    output int                o_chars_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_due;

    t_char_due  chars_due[$];
    t_phase     grp_phase  = PH_0;
    logic [3:0] carry_bits = '0;
    logic       url_safe   = 1'b0;
    int         mismatches = 0;

    function automatic logic [CHAR_W-1:0] alphabet_char(input logic [5:0] v, input logic safe);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = "A" + 8'(v);
        end else if (v < 6'd52) begin
            c = "a" + 8'(v - 6'd26);
        end else if (v < 6'd62) begin
            c = "0" + 8'(v - 6'd52);
        end else if (v == 6'd62) begin
            c = safe ? "-" : "+";
        end else begin
            c = safe ? "_" : "/";
        end
        return c[CHAR_W-1:0];
    endfunction

    function automatic void queue_char(input logic [CHAR_W-1:0] c);
        chars_due.push_back('{code: c, last: 1'b0});
    endfunction

    // Works out the characters caused by one byte and advances the group state.
    task automatic predict_chars(input logic [BYTE_W-1:0] b, input logic last);
        t_char_due tail;
        case (grp_phase)
            PH_1: begin
                queue_char(alphabet_char({carry_bits[1:0], b[7:4]}, url_safe));
                carry_bits = b[3:0];
                grp_phase  = PH_2;
                if (last) begin
                    queue_char(alphabet_char({b[3:0], 2'b00}, url_safe));
                    if (!url_safe) queue_char(PAD_CHAR);
                end
            end
            PH_2: begin
                queue_char(alphabet_char({carry_bits, b[7:6]}, url_safe));
                queue_char(alphabet_char(b[5:0], url_safe));
                carry_bits = '0;
                grp_phase  = PH_0;
            end
            default: begin
                queue_char(alphabet_char(b[7:2], url_safe));
                carry_bits = {2'b00, b[1:0]};
                grp_phase  = PH_1;
                if (last) begin
                    queue_char(alphabet_char({b[1:0], 4'b0000}, url_safe));
                    if (!url_safe) begin
                        queue_char(PAD_CHAR);
                        queue_char(PAD_CHAR);
                    end
                end
            end
        endcase
        if (last) begin
            tail      = chars_due.pop_back();
            tail.last = 1'b1;
            chars_due.push_back(tail);
            grp_phase  = PH_0;
            carry_bits = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_char_due want;
        if (!i_rst_n) begin
            chars_due.delete();
            grp_phase  = PH_0;
            carry_bits = '0;
            url_safe   = 1'b0;
        end else begin
            // Outputs are compared before new bytes are predicted, so a character
            // cannot be matched against an expectation made in the same cycle.
            if (i_out_valid && i_out_ready) begin
                if (chars_due.size() == 0) begin
                    $error("unexpected character: out_char %02h, last_char %0b",
                           i_out_char, i_last_char);
                    mismatches++;
                end else begin
                    want = chars_due.pop_front();
                    if (i_out_char !== want.code) begin
                        $error("out_char: expected %02h, actual %02h", want.code, i_out_char);
                        mismatches++;
                    end
                    if (i_last_char !== want.last) begin
                        $error("last_char: expected %0b, actual %0b", want.last, i_last_char);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) url_safe = i_cfg_url_safe_mode;
            if (i_in_valid && i_in_ready) predict_chars(i_data_byte, i_last_byte);
        end
        o_fail_count    <= mismatches;
        o_chars_pending <= chars_due.size();
    end

endmodule

/* tb/tb_base64_stream_encoder_top.sv */
// Testbench top for the Base64 stream encoder: stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_top;
    import b64enc_pkg::*;

    // A run with no transfer on any channel for this many cycles is hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles allowed after the last expected character, to catch strays.
    localparam int DRAIN_CYCLES   = 8;
    // Least number of random bytes per idling phase; four phases give at least 300 in all.
    localparam int PHASE_BYTES    = 75;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_url_safe_mode;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_data_byte;
    logic              i_last_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CHAR_W-1:0] o_out_char;
    logic              o_last_char;

    int fail_count;
    int chars_pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    base64_stream_encoder_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_url_safe_mode (i_cfg_url_safe_mode),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_char          (o_out_char),
        .o_last_char         (o_last_char)
    );

    b64enc_checker checker_inst (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_url_safe_mode (i_cfg_url_safe_mode),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_out_char          (o_out_char),
        .i_last_char         (o_last_char),
        .o_fail_count        (fail_count),
        .o_chars_pending     (chars_pending)
    );

    // The receiver decides afresh every cycle whether it stalls. A stall
    // percentage of zero keeps the output always ready.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The watchdog is cleared by any transfer on any channel. Reset, the
    // drain pauses and the longest random gaps are all far below the limit.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[base64_stream_encoder_top] ERROR");
            $finish;
        end
    end

    // Offers one byte and returns in the time step of its transfer. Before
    // the byte the sender may sit idle; if it does not, valid simply stays
    // high from the previous transfer, so it is never lowered and raised
    // again within one step.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Most bytes are uniformly random; one in eight is an all-zeros or
    // all-ones byte, which gives the first and last letters of the alphabet.
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return BYTE_W'($urandom_range(255));
    endfunction

    // Sends a message of the given length. Without the final flag the
    // message is left open, so the next byte continues the same group.
    task automatic send_message(input int len, input logic close);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), close && (i == len - 1));
        end
    endtask

    // Stops offering bytes and waits until every predicted character has
    // been taken, then a few further cycles so that no stray output slips
    // past a register write or the verdict.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the alphabet mode; only called while the encoder is idle.
    task automatic write_mode(input logic safe);
        i_cfg_valid         <= 1'b1;
        i_cfg_url_safe_mode <= safe;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        int msg_len;

        i_rst_n             <= 1'b0;
        i_cfg_valid         <= 1'b0;
        i_cfg_url_safe_mode <= 1'b0;
        i_in_valid          <= 1'b0;
        i_data_byte         <= '0;
        i_last_byte         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Standard alphabet with padding: single-byte and two-byte messages
        // at both extremes, a full group hitting sextets 62 and 63, and a
        // group followed by a one-byte tail.
        write_mode(1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // URL-safe alphabet, no padding after a short final group.
        write_mode(1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Mode changed in the middle of a message, once after the first byte
        // of a group and once after the second: the new alphabet and padding
        // rule apply to all characters from then on.
        send_byte(8'hFB, 1'b0);
        settle();
        write_mode(1'b0);
        send_byte(8'hF0, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        settle();
        write_mode(1'b1);
        send_byte(8'hBF, 1'b1);

        // Random messages in four flow-control phases. Each phase may end in
        // an unfinished message, so the following mode write also lands
        // in the middle of a group.
        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            write_mode(p[0]);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                msg_len = ($urandom_range(3) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(1, 12);
                send_message(msg_len, 1'b1);
                sent += msg_len;
            end
            if ($urandom_range(1) == 1) send_message($urandom_range(1, 2), 1'b0);
        end

        // Close any open message so that its flush is checked as well.
        send_byte(pick_byte(), 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();

        if (fail_count == 0) begin
            $display("[base64_stream_encoder_top] OK");
        end else begin
            $display("[base64_stream_encoder_top] ERROR");
        end
        $finish;
    end

endmodule
